// ----- src/framed_packet_receiver_crc16_core_macros.svh -----
// Assertion macros for the framed packet receiver core.
// Used by the top level only; the clock and reset names are fixed by the core.
`ifndef FRAMED_PACKET_RECEIVER_CRC16_CORE_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CRC16_CORE_MACROS_SVH

`ifndef SYNTH
// Checks that prop holds at every clock edge out of reset.
`define FPRC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("fprc assertion failed");
// Checks that cons holds in the cycle after ante.
`define FPRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fprc assertion failed");
`else
`define FPRC_ASSERT(label, prop)
`define FPRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/fprc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the packet receiver.
// No dependencies; used by fprc_out_skid and the top level.
`timescale 1ns / 1ps

package fprc_pkg;

    localparam int          MAX_PAYLOAD = 256;
    localparam logic [15:0] MAX_PAYLOAD_W = 16'(MAX_PAYLOAD);
    localparam int          HDR_LEN     = 11;
    localparam logic [3:0]  HDR_LAST    = 4'(HDR_LEN - 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOF_FIRST   = 2'd0;
    localparam logic [1:0] CFG_SOF_SECOND  = 2'd1;
    localparam logic [1:0] CFG_VERSION     = 2'd2;
    localparam logic [1:0] CFG_PAY_LIMIT   = 2'd3;

    typedef struct packed {
        logic        is_frame_end;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        crc_good;
        logic [7:0]  source_id;
        logic [7:0]  dest_id;
        logic [7:0]  frame_type;
        logic [15:0] command_word;
        logic [15:0] message_id;
        logic [8:0]  payload_length;
    } t_result;

    // CRC-16/CCITT-FALSE over one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- src/fprc_out_skid.sv -----
// Two-entry output buffer (output register plus skid register) for result items.
// Depends on fprc_pkg for the result type.
`timescale 1ns / 1ps

module fprc_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fprc_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output fprc_pkg::t_result o_data,
    input  logic             i_stall
);

    logic              r_out_valid;
    logic              r_skid_valid;
    fprc_pkg::t_result r_out;
    fprc_pkg::t_result r_skid;
    logic              take;

    assign take    = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // Upstream is held off while the skid register is occupied.
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

// ----- src/framed_packet_receiver_crc16_core.sv -----
// Framed packet receiver: one byte per cycle in while o_stall is low, payload and frame-end items out.
// A result is registered into the output buffer (output or skid register) when its byte is transferred.
// Throughput: one byte per cycle while o_stall is low; the CRC update and parse step are combinational.
// A two-entry output buffer lets one result wait while the next byte is taken.
// Reset (synchronous, active low) restores the default markers, version and limit,
// and puts the parser back to hunting the first start byte.
`timescale 1ns / 1ps
`include "framed_packet_receiver_crc16_core_macros.svh"

module framed_packet_receiver_crc16_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_frame_end,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic        o_crc_good,
    output logic [7:0]  o_source_id,
    output logic [7:0]  o_dest_id,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_command_word,
    output logic [15:0] o_message_id,
    output logic [8:0]  o_payload_length,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        PH_SOF1 = 3'd0,
        PH_SOF2 = 3'd1,
        PH_HDR  = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4
    } t_phase;

    logic [7:0]  r_sof_first;
    logic [7:0]  r_sof_second;
    logic [7:0]  r_version;
    logic [8:0]  r_pay_limit;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_hdr [fprc_pkg::HDR_LEN];
    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [8:0]  r_pay_cnt, n_pay_cnt;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_crc_lo,  n_crc_lo;
    logic        r_crc_cnt, n_crc_cnt;

    logic              accept;
    logic              push;
    fprc_pkg::t_result res;
    fprc_pkg::t_result out_data;
    logic              skid_full;
    logic [15:0]       crc_upd;
    logic [15:0]       hdr_len;
    logic [15:0]       new_len;
    logic [15:0]       eff_limit;
    logic [8:0]        pay_cnt_inc;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = skid_full;
    assign accept      = i_valid && !skid_full;

    assign crc_upd     = fprc_pkg::crc16_byte(r_crc, i_rx_byte);
    assign hdr_len     = {r_hdr[10], r_hdr[9]};
    assign new_len     = {i_rx_byte, r_hdr[9]};
    assign eff_limit   = ({7'd0, r_pay_limit} > fprc_pkg::MAX_PAYLOAD_W)
                         ? fprc_pkg::MAX_PAYLOAD_W : {7'd0, r_pay_limit};
    assign pay_cnt_inc = r_pay_cnt + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof_first  <= 8'hAA;
            r_sof_second <= 8'h55;
            r_version    <= 8'h01;
            r_pay_limit  <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fprc_pkg::CFG_SOF_FIRST:  r_sof_first  <= i_cfg_data[7:0];
                fprc_pkg::CFG_SOF_SECOND: r_sof_second <= i_cfg_data[7:0];
                fprc_pkg::CFG_VERSION:    r_version    <= i_cfg_data[7:0];
                fprc_pkg::CFG_PAY_LIMIT:  r_pay_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_pay_cnt = r_pay_cnt;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        n_crc_cnt = r_crc_cnt;
        push      = 1'b0;
        res       = '0;
        case (r_phase)
            PH_SOF2: begin
                if (i_rx_byte == r_sof_second) begin
                    n_phase   = PH_HDR;
                    n_hdr_cnt = 4'd0;
                    n_crc     = fprc_pkg::CRC_INIT;
                end else begin
                    n_phase   = PH_SOF1;
                    n_hdr_cnt = 4'd0;
                    n_pay_cnt = 9'd0;
                    n_crc     = fprc_pkg::CRC_INIT;
                    n_crc_lo  = 8'd0;
                    n_crc_cnt = 1'b0;
                end
            end
            PH_HDR: begin
                n_hdr_cnt = r_hdr_cnt + 4'd1;
                n_crc     = crc_upd;
                if (r_hdr_cnt == fprc_pkg::HDR_LAST) begin
                    if (r_hdr[0] != r_version || new_len > eff_limit) begin
                        n_phase   = PH_SOF1;
                        n_hdr_cnt = 4'd0;
                        n_pay_cnt = 9'd0;
                        n_crc     = fprc_pkg::CRC_INIT;
                        n_crc_lo  = 8'd0;
                        n_crc_cnt = 1'b0;
                    end else begin
                        n_pay_cnt = 9'd0;
                        n_crc_cnt = 1'b0;
                        n_phase   = (new_len == 16'd0) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_crc             = crc_upd;
                push              = 1'b1;
                res.payload_byte  = i_rx_byte;
                res.payload_index = r_pay_cnt[7:0];
                n_pay_cnt         = pay_cnt_inc;
                if ({7'd0, pay_cnt_inc} == hdr_len) begin
                    n_phase   = PH_CRC;
                    n_crc_cnt = 1'b0;
                end
            end
            PH_CRC: begin
                if (!r_crc_cnt) begin
                    n_crc_lo  = i_rx_byte;
                    n_crc_cnt = 1'b1;
                end else begin
                    push               = 1'b1;
                    res.is_frame_end   = 1'b1;
                    res.crc_good       = (r_crc == {i_rx_byte, r_crc_lo});
                    res.source_id      = r_hdr[1];
                    res.dest_id        = r_hdr[2];
                    res.frame_type     = r_hdr[3];
                    res.command_word   = {r_hdr[8], r_hdr[7]};
                    res.message_id     = {r_hdr[6], r_hdr[5]};
                    res.payload_length = hdr_len[8:0];
                    n_phase   = PH_SOF1;
                    n_hdr_cnt = 4'd0;
                    n_pay_cnt = 9'd0;
                    n_crc     = fprc_pkg::CRC_INIT;
                    n_crc_lo  = 8'd0;
                    n_crc_cnt = 1'b0;
                end
            end
            default: begin
                // Hunting the first marker; unused phase codes land here too.
                n_phase = (i_rx_byte == r_sof_first) ? PH_SOF2 : PH_SOF1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SOF1;
            r_hdr_cnt <= 4'd0;
            r_pay_cnt <= 9'd0;
            r_crc     <= fprc_pkg::CRC_INIT;
            r_crc_lo  <= 8'd0;
            r_crc_cnt <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_pay_cnt <= n_pay_cnt;
            r_crc     <= n_crc;
            r_crc_lo  <= n_crc_lo;
            r_crc_cnt <= n_crc_cnt;
        end
    end

    // The header counter stays below the header length while in the header phase.
    always_ff @(posedge i_clk) begin
        if (accept && r_phase == PH_HDR) begin
            r_hdr[r_hdr_cnt] <= i_rx_byte;
        end
    end

    fprc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && push),
        .i_data  (res),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_stall (i_stall)
    );

    assign o_is_frame_end   = out_data.is_frame_end;
    assign o_payload_byte   = out_data.payload_byte;
    assign o_payload_index  = out_data.payload_index;
    assign o_crc_good       = out_data.crc_good;
    assign o_source_id      = out_data.source_id;
    assign o_dest_id        = out_data.dest_id;
    assign o_frame_type     = out_data.frame_type;
    assign o_command_word   = out_data.command_word;
    assign o_message_id     = out_data.message_id;
    assign o_payload_length = out_data.payload_length;

    `FPRC_ASSERT(a_stall_needs_result, !o_stall || o_valid)
    `FPRC_ASSERT_NEXT(a_push_shows_result, accept && push, o_valid)
    `FPRC_ASSERT(a_hdr_cnt_range, r_phase != PH_HDR || r_hdr_cnt < 4'd11)
    `FPRC_ASSERT(a_pay_cnt_below_len, r_phase != PH_DATA || 16'(r_pay_cnt) < hdr_len)

endmodule

// ----- bench/tb_framed_packet_receiver_crc16_core.sv -----
// Self-checking bench for the framed packet receiver: frames go in byte by byte,
// payload and frame-end transfers are checked against a cycle-free parser model.
// Depends on fprc_pkg and framed_packet_receiver_crc16_core.
`timescale 1ns / 1ps

module tb_framed_packet_receiver_crc16_core;

    typedef enum logic [2:0] {
        PH_HUNT_FIRST,
        PH_HUNT_SECOND,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC
    } t_parse_phase;

    // Parser model: tracks the frame being received and queues the transfers
    // that each accepted byte should produce.
    class frame_decoder;
        logic [7:0]        sof_first;
        logic [7:0]        sof_second;
        logic [7:0]        version;
        logic [8:0]        limit_reg;
        t_parse_phase      phase;
        logic [7:0]        hdr [11];
        int                hdr_cnt;
        logic [8:0]        pay_cnt;
        logic [15:0]       crc;
        logic [7:0]        crc_lo;
        bit                crc_half;
        fprc_pkg::t_result pending [$];
        int                errors;

        function new();
            sof_first  = 8'hAA;
            sof_second = 8'h55;
            version    = 8'h01;
            limit_reg  = 9'd256;
            errors     = 0;
            restart();
        endfunction

        // Bit-serial form of CRC-16/CCITT-FALSE, MSB first.
        static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 7; i >= 0; i--) begin
                fb = r[15] ^ b[i];
                r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
            end
            return r;
        endfunction

        function void restart();
            phase    = PH_HUNT_FIRST;
            hdr_cnt  = 0;
            pay_cnt  = '0;
            crc      = 16'hFFFF;
            crc_lo   = '0;
            crc_half = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [8:0] data);
            case (idx)
                fprc_pkg::CFG_SOF_FIRST:  sof_first  = data[7:0];
                fprc_pkg::CFG_SOF_SECOND: sof_second = data[7:0];
                fprc_pkg::CFG_VERSION:    version    = data[7:0];
                fprc_pkg::CFG_PAY_LIMIT:  limit_reg  = data;
                default: ;
            endcase
        endfunction

        function logic [15:0] header_word(input int pos);
            return {hdr[pos + 1], hdr[pos]};
        endfunction

        function void take_byte(input logic [7:0] b);
            fprc_pkg::t_result r;
            logic [15:0]       len;
            int                lim;
            r   = '0;
            len = header_word(9);
            case (phase)
                PH_HUNT_SECOND: begin
                    if (b == sof_second) begin
                        phase   = PH_HEADER;
                        hdr_cnt = 0;
                        crc     = 16'hFFFF;
                    end else begin
                        restart();
                    end
                end
                PH_HEADER: begin
                    hdr[hdr_cnt] = b;
                    hdr_cnt++;
                    crc = crc_step(crc, b);
                    if (hdr_cnt == 11) begin
                        len = header_word(9);
                        lim = (limit_reg > 9'd256) ? 256 : int'(limit_reg);
                        if (hdr[0] != version || int'(len) > lim) begin
                            restart();
                        end else begin
                            pay_cnt  = '0;
                            crc_half = 0;
                            phase    = (len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    crc             = crc_step(crc, b);
                    r.payload_byte  = b;
                    r.payload_index = pay_cnt[7:0];
                    pending.push_back(r);
                    pay_cnt++;
                    if ({7'd0, pay_cnt} == len) begin
                        phase    = PH_CRC;
                        crc_half = 0;
                    end
                end
                PH_CRC: begin
                    if (!crc_half) begin
                        crc_lo   = b;
                        crc_half = 1;
                    end else begin
                        r.is_frame_end   = 1'b1;
                        r.crc_good       = (crc == {b, crc_lo});
                        r.source_id      = hdr[1];
                        r.dest_id        = hdr[2];
                        r.frame_type     = hdr[3];
                        r.message_id     = header_word(5);
                        r.command_word   = header_word(7);
                        r.payload_length = len[8:0];
                        pending.push_back(r);
                        restart();
                    end
                end
                default: begin
                    phase = (b == sof_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
                end
            endcase
        endfunction

        function void check_field(input string nm, input logic [15:0] e, input logic [15:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t %s mismatch: expected %0h, got %0h", $time, nm, e, a);
            end
        endfunction

        function void match_result(input fprc_pkg::t_result got);
            fprc_pkg::t_result e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer: expected none, got %h", $time, got);
                return;
            end
            e = pending.pop_front();
            check_field("is_frame_end", e.is_frame_end, got.is_frame_end);
            check_field("payload_byte", e.payload_byte, got.payload_byte);
            check_field("payload_index", e.payload_index, got.payload_index);
            check_field("crc_good", e.crc_good, got.crc_good);
            check_field("source_id", e.source_id, got.source_id);
            check_field("dest_id", e.dest_id, got.dest_id);
            check_field("frame_type", e.frame_type, got.frame_type);
            check_field("command_word", e.command_word, got.command_word);
            check_field("message_id", e.message_id, got.message_id);
            check_field("payload_length", e.payload_length, got.payload_length);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_rx_byte;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall;
    logic        o_is_frame_end;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_payload_index;
    logic        o_crc_good;
    logic [7:0]  o_source_id;
    logic [7:0]  o_dest_id;
    logic [7:0]  o_frame_type;
    logic [15:0] o_command_word;
    logic [15:0] o_message_id;
    logic [8:0]  o_payload_length;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    frame_decoder      dec;
    fprc_pkg::t_result seen;
    int                tx_idle_pct    = 0;
    int                rx_stall_pct   = 0;
    int                rx_hold_cycles = 0;

    framed_packet_receiver_crc16_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_rx_byte        (i_rx_byte),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_is_frame_end   (o_is_frame_end),
        .o_payload_byte   (o_payload_byte),
        .o_payload_index  (o_payload_index),
        .o_crc_good       (o_crc_good),
        .o_source_id      (o_source_id),
        .o_dest_id        (o_dest_id),
        .o_frame_type     (o_frame_type),
        .o_command_word   (o_command_word),
        .o_message_id     (o_message_id),
        .o_payload_length (o_payload_length),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side: stall pattern changes at the falling edge, a long hold-off
    // takes priority over the random pattern.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_stall = 1'b1;
                rx_hold_cycles--;
            end else begin
                i_stall = ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen.is_frame_end   = o_is_frame_end;
            seen.payload_byte   = o_payload_byte;
            seen.payload_index  = o_payload_index;
            seen.crc_good       = o_crc_good;
            seen.source_id      = o_source_id;
            seen.dest_id        = o_dest_id;
            seen.frame_type     = o_frame_type;
            seen.command_word   = o_command_word;
            seen.message_id     = o_message_id;
            seen.payload_length = o_payload_length;
            dec.match_result(seen);
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        dec.take_byte(b);
    endtask

    // Drops the byte valid and waits until every predicted transfer is out.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (dec.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        dec.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [7:0] sf, input logic [7:0] ss,
                             input logic [7:0] ver, input logic [8:0] lim);
        drain();
        write_cfg(fprc_pkg::CFG_SOF_FIRST, {1'b0, sf});
        write_cfg(fprc_pkg::CFG_SOF_SECOND, {1'b0, ss});
        write_cfg(fprc_pkg::CFG_VERSION, {1'b0, ver});
        write_cfg(fprc_pkg::CFG_PAY_LIMIT, lim);
    endtask

    // Builds a frame with the current markers and sends the first keep bytes
    // of it (all of it when keep is zero).
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] src,
                              input logic [7:0] dst, input logic [7:0] ftype,
                              input logic [7:0] flags, input logic [15:0] msg_id,
                              input logic [15:0] cmd, input logic [15:0] len,
                              input bit bad_crc, input int keep, output int sent);
        logic [7:0]  fbytes [$];
        logic [15:0] c;
        int          n;
        fbytes = {};
        fbytes.push_back(dec.sof_first);
        fbytes.push_back(dec.sof_second);
        fbytes.push_back(ver);
        fbytes.push_back(src);
        fbytes.push_back(dst);
        fbytes.push_back(ftype);
        fbytes.push_back(flags);
        fbytes.push_back(msg_id[7:0]);
        fbytes.push_back(msg_id[15:8]);
        fbytes.push_back(cmd[7:0]);
        fbytes.push_back(cmd[15:8]);
        fbytes.push_back(len[7:0]);
        fbytes.push_back(len[15:8]);
        // Very long rejected lengths get no payload; the parser drops them anyway.
        if (len <= 16'd300) begin
            for (int i = 0; i < int'(len); i++) fbytes.push_back(8'($urandom));
        end
        c = 16'hFFFF;
        for (int i = 2; i < fbytes.size(); i++) c = frame_decoder::crc_step(c, fbytes[i]);
        if (bad_crc) c = c ^ (16'd1 << $urandom_range(15));
        fbytes.push_back(c[7:0]);
        fbytes.push_back(c[15:8]);
        n = (keep > 0 && keep < fbytes.size()) ? keep : fbytes.size();
        for (int i = 0; i < n; i++) send_byte(fbytes[i]);
        sent = n;
    endtask

    function automatic logic [15:0] pick_len(input int lim);
        int r;
        int cap;
        r   = $urandom_range(99);
        cap = (r < 70) ? 12 : ((r < 95) ? 40 : lim);
        if (cap > lim) cap = lim;
        return 16'($urandom_range(cap, 0));
    endfunction

    task automatic send_random_frame(output int sent);
        int          r;
        int          lim;
        logic [15:0] len;
        logic [7:0]  ver;
        bit          bad;
        int          keep;
        lim  = (dec.limit_reg > 9'd256) ? 256 : int'(dec.limit_reg);
        ver  = dec.version;
        bad  = 0;
        keep = 0;
        len  = pick_len(lim);
        r    = $urandom_range(99);
        if (r < 9) begin
            bad = 1;
        end else if (r < 14) begin
            ver = ver ^ 8'($urandom_range(255, 1));
        end else if (r < 19) begin
            len = ($urandom_range(9) == 0) ? 16'hFFFF : 16'(lim + $urandom_range(3, 1));
        end else if (r < 25) begin
            keep = $urandom_range(14 + int'(len), 1);
        end
        send_frame(ver, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), len, bad, keep, sent);
    endtask

    // Mostly well-formed frames with random content; line noise now and then.
    task automatic run_random(input int target);
        int total;
        int n;
        total = 0;
        while (total < target) begin
            if ($urandom_range(99) < 6) begin
                repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
            end else begin
                send_random_frame(n);
                total += n;
            end
        end
    endtask

    initial begin
        int n;
        int spins;
        dec         = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_rx_byte   = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_index = fprc_pkg::CFG_SOF_FIRST;
        i_cfg_data  = 9'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: noise, a second marker mismatch whose byte is a first
        // marker, empty and full-range headers, bad CRC, wrong version, overlong.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_frame(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'd0, 0, 0, n);
        send_frame(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'd3, 0, 0, n);
        send_frame(8'h01, 8'h12, 8'h34, 8'h56, 8'h00, 16'h1234, 16'hABCD, 16'd2, 1, 0, n);
        send_frame(8'h02, 8'h01, 8'h02, 8'h03, 8'h00, 16'h0001, 16'h0002, 16'd1, 0, 0, n);
        send_frame(8'h01, 8'h01, 8'h02, 8'h03, 8'h00, 16'h0001, 16'h0002, 16'd257, 0, 13, n);
        send_frame(8'h01, 8'h01, 8'h02, 8'h03, 8'h00, 16'h0001, 16'h0002, 16'hFFFF, 0, 0, n);

        // Long hold-off on the result side while bytes keep coming.
        rx_hold_cycles = 80;
        send_frame(8'h01, 8'h21, 8'h43, 8'h65, 8'h00, 16'h0BAD, 16'hF00D, 16'd40, 0, 0, n);
        run_random(100);

        // Extreme markers (00 and FF), top version, zero payload limit; sender idles.
        configure(8'h00, 8'hFF, 8'hFF, 9'd0);
        tx_idle_pct = 80;
        send_frame(8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0102, 16'h0304, 16'd0, 0, 0, n);
        send_frame(8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 16'h0102, 16'h0304, 16'd1, 0, 0, n);
        run_random(60);

        // Limit register above range acts as the maximum payload of 256; receiver stalls.
        tx_idle_pct  = 0;
        rx_stall_pct = 80;
        configure(8'hFF, 8'h00, 8'h00, 9'h1FF);
        send_frame(8'h00, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 16'h8001, 16'h7FFE, 16'd256, 0, 0, n);
        send_frame(8'h00, 8'h5A, 8'hA5, 8'h3C, 8'hC3, 16'h7FFE, 16'h8001, 16'd256, 1, 0, n);
        send_frame(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 16'h0101, 16'h0101, 16'd257, 0, 13, n);
        run_random(100);

        // Random markers, version and a small limit; both sides idle lightly,
        // with a pause in the middle until everything has drained.
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        configure(8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom_range(40, 1)));
        run_random(40);
        drain();
        run_random(40);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        configure(8'hAA, 8'h55, 8'h01, 9'd256);
        run_random(80);

        @(negedge i_clk);
        i_valid = 1'b0;
        spins   = 0;
        while (dec.outstanding() != 0 && spins < 20000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (8) @(posedge i_clk);
        if (dec.errors == 0 && dec.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (dec.outstanding() != 0) begin
                $display("%0t %0d expected transfers never arrived", $time, dec.outstanding());
            end
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
